// ===== hw/rtl/grid_auto_placement_unit_defines.svh =====
// Assertion macros for the grid placement checker
`ifndef GRID_AUTO_PLACEMENT_UNIT_DEFINES_SVH
`define GRID_AUTO_PLACEMENT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define GAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gap_pkg.sv =====
// Types and fixed widths for the grid placement unit
`default_nettype none

package gap_pkg;

  // Widths fixed by the request and result fields
  localparam int CNT_W     = 5;  // column count and column span
  localparam int SPAN_W    = 6;  // requested spans, row span
  localparam int ROW_OUT_W = 7;  // reported top row
  localparam int COL_OUT_W = 4;  // reported left column

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_MARK,
    ST_DONE
  } gap_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/gap_occ_ram.sv =====
// Occupancy row memory: one write port, one registered read port
`default_nettype none

module gap_occ_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/grid_auto_placement_unit.sv =====
// Grid auto-placement unit: finds the first free spot for each rectangle request
//
//   channel   | signals                                      | handshake
//   ----------+----------------------------------------------+---------------------------
//   config    | cfg_we_i, cfg_wdata_i                        | written when cfg_we_i high
//   request   | col_span_i, row_span_i, last_item_i          | taken on start && !busy
//   result    | place_row_o, place_column_o, used_*_o, ovf   | valid for one cycle, done_o
//
// Each tried top row reads the occupied-region rows under the candidate window (at most
// row_span) through the single read port of the occupancy memory; the chosen spot then
// reads, merges and writes back in turn each row of its row span, clipped to MAX_ROWS.
// Rows at or past a high-water mark read as free, so neither reset nor the last request
// of a sequence needs a clearing pass. The receiver cannot stall; busy stays high from
// the accepted request through the cycle that shows done_o.
`default_nettype none

module grid_auto_placement_unit #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [gap_pkg::CNT_W-1:0]       cfg_wdata_i,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [gap_pkg::SPAN_W-1:0]      col_span_i,
  input  wire logic [gap_pkg::SPAN_W-1:0]      row_span_i,
  input  wire logic                            last_item_i,
  output logic                                 done_o,
  output logic      [gap_pkg::ROW_OUT_W-1:0]   place_row_o,
  output logic      [gap_pkg::COL_OUT_W-1:0]   place_column_o,
  output logic      [gap_pkg::CNT_W-1:0]       used_col_span_o,
  output logic      [gap_pkg::SPAN_W-1:0]      used_row_span_o,
  output logic                                 overflow_o
);

  import gap_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);   // row values 0..MAX_ROWS
  localparam int SW = $clog2(MAX_ROWS + 64);  // row plus row span
  localparam int AW = $clog2(MAX_ROWS);       // memory address
  localparam logic [SW-1:0] MAXR_S = SW'(MAX_ROWS);
  localparam logic [RW-1:0] MAXR_R = RW'(MAX_ROWS);

  gap_state_e state_q, state_d;

  logic [CNT_W-1:0]       cfg_q;
  logic [CNT_W-1:0]       cs_q, cs_d;
  logic [SPAN_W-1:0]      rs_q, rs_d;
  logic                   last_q, last_d;
  logic [RW-1:0]          row_q, row_d;
  logic [CNT_W-1:0]       cstart_q, cstart_d;
  logic [CNT_W-1:0]       col_q, col_d;
  logic [MAX_COLUMNS-1:0] acc_q, acc_d;
  logic [MAX_COLUMNS-1:0] mask_q, mask_d;
  logic [RW-1:0]          ptr_q, ptr_d;
  logic [RW-1:0]          wrow_q, wrow_d;
  logic                   rdv_q, rdv_d;
  logic [RW-1:0]          cur_row_q, cur_row_d;
  logic [CNT_W-1:0]       cur_col_q, cur_col_d;
  logic [RW-1:0]          hw_q, hw_d;

  logic [CNT_W-1:0]       cols;
  logic [CNT_W-1:0]       cs_in;
  logic [SPAN_W-1:0]      rs_in;
  logic [SW-1:0]          sum_s;
  logic [RW-1:0]          scan_end;
  logic [RW-1:0]          mark_end;
  logic [MAX_COLUMNS-1:0] base;
  logic [MAX_COLUMNS-1:0] fit;
  logic                   found;
  logic [CNT_W-1:0]       found_c;
  logic [CNT_W:0]         ncol;
  logic                   rd_en, wr_en;
  logic [MAX_COLUMNS-1:0] rd_data, wr_data;

  // Occupancy memory
  gap_occ_ram #(
    .DEPTH (MAX_ROWS),
    .WIDTH (MAX_COLUMNS)
  ) u_occ_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wrow_q[AW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // Active column count: zero acts as one, saturates at MAX_COLUMNS
  always_comb begin
    if (cfg_q == '0) begin
      cols = CNT_W'(1);
    end else if (int'(cfg_q) > MAX_COLUMNS) begin
      cols = CNT_W'(MAX_COLUMNS);
    end else begin
      cols = cfg_q;
    end
  end

  // Span clamping on the incoming request
  always_comb begin
    if (col_span_i > SPAN_W'(cols)) begin
      cs_in = cols;
    end else if (col_span_i == '0) begin
      cs_in = CNT_W'(1);
    end else begin
      cs_in = col_span_i[CNT_W-1:0];
    end
    rs_in = (row_span_i == '0) ? SPAN_W'(1) : row_span_i;
  end

  // Window bounds for the current top row
  always_comb begin
    sum_s    = SW'(row_q) + SW'(rs_q);
    scan_end = (sum_s < SW'(hw_q)) ? RW'(sum_s) : hw_q;
    mark_end = (sum_s < MAXR_S) ? RW'(sum_s) : MAXR_R;
  end

  // Column fit over the OR of the window rows; lowest column wins
  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      base[i] = (i < int'(cs_q));
    end
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      fit[c] = (((acc_q >> c) & base) == '0) && (c >= int'(cstart_q)) &&
               ((c + int'(cs_q)) <= int'(cols));
    end
    found   = 1'b0;
    found_c = '0;
    for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
      if (fit[c]) begin
        found   = 1'b1;
        found_c = CNT_W'(c);
      end
    end
  end

  // Rows at or past the high-water mark hold stale data and read as free
  assign wr_data = ((wrow_q < hw_q) ? rd_data : '0) | mask_q;
  assign ncol    = {1'b0, col_q} + {1'b0, cs_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start) state_d = ST_SCAN;
      ST_SCAN:  if (ptr_q >= scan_end) state_d = ST_CHECK;
      ST_CHECK: state_d = found ? ST_MARK : ST_SCAN;
      ST_MARK:  if (ptr_q >= mark_end) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cs_d      = cs_q;
    rs_d      = rs_q;
    last_d    = last_q;
    row_d     = row_q;
    cstart_d  = cstart_q;
    col_d     = col_q;
    acc_d     = acc_q;
    mask_d    = mask_q;
    ptr_d     = ptr_q;
    wrow_d    = wrow_q;
    rdv_d     = 1'b0;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    hw_d      = hw_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cs_d     = cs_in;
          rs_d     = rs_in;
          last_d   = last_item_i;
          row_d    = cur_row_q;
          cstart_d = cur_col_q;
          acc_d    = '0;
          ptr_d    = cur_row_q;
        end
      end
      // OR together the live rows under the candidate window
      ST_SCAN: begin
        if (rdv_q) begin
          acc_d = acc_q | rd_data;
        end
        if (ptr_q < scan_end) begin
          rd_en = 1'b1;
          rdv_d = 1'b1;
          ptr_d = ptr_q + 1'b1;
        end
      end
      // Take the spot, or move to the next top row from column zero
      ST_CHECK: begin
        if (found) begin
          col_d  = found_c;
          mask_d = base << found_c;
          ptr_d  = row_q;
        end else begin
          row_d    = (row_q < MAXR_R) ? row_q + 1'b1 : row_q;
          ptr_d    = (row_q < MAXR_R) ? row_q + 1'b1 : row_q;
          cstart_d = '0;
          acc_d    = '0;
        end
      end
      // Read, merge and write back each covered row
      ST_MARK: begin
        if (rdv_q) begin
          wr_en = 1'b1;
        end
        if (ptr_q < mark_end) begin
          rd_en  = 1'b1;
          rdv_d  = 1'b1;
          wrow_d = ptr_q;
          ptr_d  = ptr_q + 1'b1;
        end
      end
      // Advance the cursor and the high-water mark, or clear both after the last request
      ST_DONE: begin
        if (ncol >= {1'b0, cols}) begin
          cur_col_d = '0;
          cur_row_d = (row_q < MAXR_R) ? row_q + 1'b1 : row_q;
        end else begin
          cur_col_d = ncol[CNT_W-1:0];
          cur_row_d = row_q;
        end
        hw_d = (mark_end > hw_q) ? mark_end : hw_q;
        if (last_q) begin
          cur_col_d = '0;
          cur_row_d = '0;
          hw_d      = '0;
        end
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    busy            = (state_q != ST_IDLE);
    done_o          = (state_q == ST_DONE);
    place_row_o     = ROW_OUT_W'(row_q);
    place_column_o  = COL_OUT_W'(col_q);
    used_col_span_o = cs_q;
    used_row_span_o = rs_q;
    overflow_o      = (sum_s > MAXR_S);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= CNT_W'(1);
      rdv_q     <= 1'b0;
      cur_row_q <= '0;
      cur_col_q <= '0;
      hw_q      <= '0;
    end else begin
      state_q   <= state_d;
      rdv_q     <= rdv_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      hw_q      <= hw_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cs_q     <= cs_d;
    rs_q     <= rs_d;
    last_q   <= last_d;
    row_q    <= row_d;
    cstart_q <= cstart_d;
    col_q    <= col_d;
    acc_q    <= acc_d;
    mask_q   <= mask_d;
    ptr_q    <= ptr_d;
    wrow_q   <= wrow_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/grid_auto_placement_unit_chk.sv =====
// Port-level checker for the grid placement unit, bound to the top level
`default_nettype none
`include "grid_auto_placement_unit_defines.svh"

module grid_auto_placement_unit_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic [4:0] used_col_span_o,
  input wire logic [5:0] used_row_span_o
);

  // A result only appears while a request is in flight
  `GAP_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy, "result without busy")

  // An accepted request makes the unit busy
  `GAP_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "request not taken")

  // Exactly one result per request, then idle
  `GAP_ASSERT_NXT(a_done_once, clk_i, rst_ni, done_o, !busy && !done_o, "result repeated")

  // Reported spans are clamped to at least one
  `GAP_ASSERT_IMP(a_span_nz, clk_i, rst_ni, done_o,
                  (used_col_span_o != 5'd0) && (used_row_span_o != 6'd0), "zero span")

endmodule

bind grid_auto_placement_unit grid_auto_placement_unit_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .used_col_span_o (used_col_span_o),
  .used_row_span_o (used_row_span_o)
);

`default_nettype wire

// ===== tb/sv/tb_grid_auto_placement_unit.sv =====
// Self-checking testbench for the grid auto-placement unit: directed table, then random sequences
`timescale 1ns / 100ps

module tb_grid_auto_placement_unit;

  import gap_pkg::*;

  localparam int GRID_COLS_MAX = 16;
  localparam int GRID_ROWS_MAX = 64;
  localparam int WATCHDOG      = 300000;
  localparam int N_PHASES      = 10;
  localparam int PHASE_ITEMS   = 105;

  // One placement as reported by the block
  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [CNT_W-1:0]     cspan;
    logic [SPAN_W-1:0]    rspan;
    logic                 ovf;
  } placement_t;

  // Directed table row: optional column count write, then one request
  typedef struct packed {
    logic              wr_cols;
    logic [CNT_W-1:0]  cols;
    logic [SPAN_W-1:0] cs;
    logic [SPAN_W-1:0] rs;
    logic              last;
    logic              typed;
    placement_t        want;
  } dir_row_t;

  localparam int N_DIR = 21;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata_i = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [SPAN_W-1:0]    col_span_i = '0;
  logic [SPAN_W-1:0]    row_span_i = '0;
  logic                 last_item_i = 1'b0;
  logic                 done_o;
  logic [ROW_OUT_W-1:0] place_row_o;
  logic [COL_OUT_W-1:0] place_column_o;
  logic [CNT_W-1:0]     used_col_span_o;
  logic [SPAN_W-1:0]    used_row_span_o;
  logic                 overflow_o;

  // Predictor state
  logic [GRID_COLS_MAX-1:0] occ_rows [GRID_ROWS_MAX];
  int                       cur_row;
  int                       cur_col;
  logic [CNT_W-1:0]         grid_cols;

  placement_t placements_due[$];
  int         errors      = 0;
  int         n_requests  = 0;
  int         n_results   = 0;
  int         n_overflows = 0;
  int         n_cfg       = 0;
  int         n_seqs      = 0;
  int         quiet_cycles = 0;
  bit         gaps_on     = 1'b1;

  dir_row_t directed [N_DIR] = '{
    '{1'b0, 5'd0,  6'd0,  6'd0,  1'b0, 1'b1, '{7'd0,  4'd0,  5'd1,  6'd1,  1'b0}},
    '{1'b0, 5'd0,  6'd63, 6'd63, 1'b1, 1'b1, '{7'd1,  4'd0,  5'd1,  6'd63, 1'b0}},
    '{1'b1, 5'd0,  6'd5,  6'd1,  1'b0, 1'b1, '{7'd0,  4'd0,  5'd1,  6'd1,  1'b0}},
    '{1'b0, 5'd0,  6'd1,  6'd63, 1'b0, 1'b1, '{7'd1,  4'd0,  5'd1,  6'd63, 1'b0}},
    '{1'b0, 5'd0,  6'd1,  6'd1,  1'b0, 1'b1, '{7'd64, 4'd0,  5'd1,  6'd1,  1'b1}},
    '{1'b0, 5'd0,  6'd2,  6'd2,  1'b1, 1'b1, '{7'd64, 4'd0,  5'd1,  6'd2,  1'b1}},
    '{1'b1, 5'd16, 6'd16, 6'd1,  1'b0, 1'b1, '{7'd0,  4'd0,  5'd16, 6'd1,  1'b0}},
    '{1'b0, 5'd0,  6'd63, 6'd2,  1'b0, 1'b1, '{7'd1,  4'd0,  5'd16, 6'd2,  1'b0}},
    '{1'b0, 5'd0,  6'd3,  6'd1,  1'b0, 1'b1, '{7'd3,  4'd0,  5'd3,  6'd1,  1'b0}},
    '{1'b0, 5'd0,  6'd15, 6'd1,  1'b0, 1'b1, '{7'd4,  4'd0,  5'd15, 6'd1,  1'b0}},
    '{1'b0, 5'd0,  6'd1,  6'd1,  1'b1, 1'b1, '{7'd4,  4'd15, 5'd1,  6'd1,  1'b0}},
    '{1'b1, 5'd17, 6'd16, 6'd63, 1'b0, 1'b1, '{7'd0,  4'd0,  5'd16, 6'd63, 1'b0}},
    '{1'b0, 5'd0,  6'd1,  6'd1,  1'b0, 1'b1, '{7'd63, 4'd0,  5'd1,  6'd1,  1'b0}},
    '{1'b0, 5'd0,  6'd1,  6'd2,  1'b0, 1'b1, '{7'd63, 4'd1,  5'd1,  6'd2,  1'b1}},
    '{1'b1, 5'd4,  6'd4,  6'd1,  1'b0, 1'b1, '{7'd64, 4'd0,  5'd4,  6'd1,  1'b1}},
    '{1'b0, 5'd0,  6'd0,  6'd0,  1'b1, 1'b1, '{7'd64, 4'd0,  5'd1,  6'd1,  1'b1}},
    '{1'b1, 5'd31, 6'd63, 6'd1,  1'b1, 1'b1, '{7'd0,  4'd0,  5'd16, 6'd1,  1'b0}},
    '{1'b1, 5'd3,  6'd2,  6'd3,  1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  6'd2,  6'd1,  1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  6'd0,  6'd2,  1'b0, 1'b0, '0},
    '{1'b0, 5'd0,  6'd42, 6'd21, 1'b1, 1'b0, '0}
  };

  grid_auto_placement_unit #(
    .MAX_COLUMNS(GRID_COLS_MAX),
    .MAX_ROWS   (GRID_ROWS_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .col_span_i     (col_span_i),
    .row_span_i     (row_span_i),
    .last_item_i    (last_item_i),
    .done_o         (done_o),
    .place_row_o    (place_row_o),
    .place_column_o (place_column_o),
    .used_col_span_o(used_col_span_o),
    .used_row_span_o(used_row_span_o),
    .overflow_o     (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Column count in effect: zero acts as one, saturates at the grid width
  function automatic int active_cols();
    int c;
    c = int'(grid_cols);
    if (c == 0) c = 1;
    if (c > GRID_COLS_MAX) c = GRID_COLS_MAX;
    return c;
  endfunction

  function automatic logic [GRID_COLS_MAX-1:0] span_bits(int c, int cs);
    logic [31:0] m;
    m = ((32'd1 << cs) - 32'd1) << c;
    return m[GRID_COLS_MAX-1:0];
  endfunction

  // Rectangle fits the row width and covers only free stored cells
  function automatic bit spot_free(int r, int c, int cs, int rs, int cols);
    logic [GRID_COLS_MAX-1:0] m;
    if (c + cs > cols) return 1'b0;
    m = span_bits(c, cs);
    for (int rr = r; rr < r + rs && rr < GRID_ROWS_MAX; rr++)
      if ((occ_rows[rr] & m) != '0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_grid();
    for (int i = 0; i < GRID_ROWS_MAX; i++) occ_rows[i] = '0;
    cur_row = 0;
    cur_col = 0;
  endfunction

  // Places one request, updates the grid state and returns the placement
  function automatic placement_t place_rect(logic [SPAN_W-1:0] cs_in,
                                            logic [SPAN_W-1:0] rs_in, logic last);
    int         cols, cs, rs, r, c;
    placement_t p;
    logic [GRID_COLS_MAX-1:0] m;
    cols = active_cols();
    cs = int'(cs_in);
    rs = int'(rs_in);
    if (cs > cols) cs = cols;
    if (cs == 0) cs = 1;
    if (rs == 0) rs = 1;
    r = (cur_row > GRID_ROWS_MAX) ? GRID_ROWS_MAX : cur_row;
    c = cur_col;
    while (!spot_free(r, c, cs, rs, cols)) begin
      c++;
      if (c >= cols) begin
        c = 0;
        if (r < GRID_ROWS_MAX) r++;
      end
    end
    m = span_bits(c, cs);
    for (int rr = r; rr < r + rs && rr < GRID_ROWS_MAX; rr++) occ_rows[rr] |= m;
    p.row   = r[ROW_OUT_W-1:0];
    p.col   = c[COL_OUT_W-1:0];
    p.cspan = cs[CNT_W-1:0];
    p.rspan = rs[SPAN_W-1:0];
    p.ovf   = (r + rs) > GRID_ROWS_MAX;
    cur_row = r;
    cur_col = c + cs;
    if (cur_col >= cols) begin
      cur_col = 0;
      if (cur_row < GRID_ROWS_MAX) cur_row++;
    end
    if (last) clear_grid();
    return p;
  endfunction

  // Sender: optional gap, then hold the request until it is taken
  task automatic issue_request(logic [SPAN_W-1:0] cs, logic [SPAN_W-1:0] rs, logic last,
                               bit typed, placement_t want);
    placement_t got;
    if (gaps_on && $urandom_range(99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start       <= 1'b1;
    col_span_i  <= cs;
    row_span_i  <= rs;
    last_item_i <= last;
    do @(posedge clk_i); while (busy);
    got = place_rect(cs, rs, last);
    placements_due.insert(placements_due.size(), typed ? want : got);
    n_requests++;
    if (last) n_seqs++;
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every placement has come back
  task automatic hold_until_drained();
    start <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_columns(logic [CNT_W-1:0] v);
    hold_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    grid_cols = v;
    n_cfg++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Result checker and watchdog
  always @(posedge clk_i) begin
    placement_t exp_p;
    if (rst_ni) begin
      if (done_o) begin
        n_results++;
        if (overflow_o) n_overflows++;
        if (placements_due.size() == 0) begin
          $display("%0t: result expected none got row %0d col %0d", $time, place_row_o,
                   place_column_o);
          errors++;
        end else begin
          exp_p = placements_due.pop_front();
          if (place_row_o !== exp_p.row) begin
            $display("%0t: place_row expected %0d got %0d", $time, exp_p.row, place_row_o);
            errors++;
          end
          if (place_column_o !== exp_p.col) begin
            $display("%0t: place_column expected %0d got %0d", $time, exp_p.col,
                     place_column_o);
            errors++;
          end
          if (used_col_span_o !== exp_p.cspan) begin
            $display("%0t: used_col_span expected %0d got %0d", $time, exp_p.cspan,
                     used_col_span_o);
            errors++;
          end
          if (used_row_span_o !== exp_p.rspan) begin
            $display("%0t: used_row_span expected %0d got %0d", $time, exp_p.rspan,
                     used_row_span_o);
            errors++;
          end
          if (overflow_o !== exp_p.ovf) begin
            $display("%0t: overflow expected %0d got %0d", $time, exp_p.ovf, overflow_o);
            errors++;
          end
        end
      end
      if (done_o || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: watchdog expired, %0d placements outstanding", $time,
                 placements_due.size());
        $display("tb_grid_auto_placement_unit: done, errors");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [CNT_W-1:0]  plan [N_PHASES];
    logic [SPAN_W-1:0] cs, rs;
    logic              last;
    int                seq_left, cols, pick;
    plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
    for (int i = 5; i < N_PHASES; i++) plan[i] = CNT_W'($urandom_range(0, 31));
    grid_cols = 5'd1;
    clear_grid();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (directed[i].wr_cols) write_columns(directed[i].cols);
      issue_request(directed[i].cs, directed[i].rs, directed[i].last, directed[i].typed,
                    directed[i].want);
    end

    // Random sequences; one phase runs without gaps
    seq_left = 0;
    for (int p = 0; p < N_PHASES; p++) begin
      write_columns(plan[p]);
      gaps_on = (p != 4);
      cols = active_cols();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == 50 && p == 2) hold_until_drained();
        if (seq_left == 0) seq_left = $urandom_range(1, 14);
        pick = $urandom_range(99);
        cs = (pick < 70) ? SPAN_W'($urandom_range(0, cols + 1)) :
                           SPAN_W'($urandom_range(0, 63));
        pick = $urandom_range(99);
        if (pick < 80) rs = SPAN_W'($urandom_range(0, 3));
        else if (pick < 95) rs = SPAN_W'($urandom_range(4, 12));
        else rs = SPAN_W'($urandom_range(13, 63));
        last = (seq_left == 1) || ($urandom_range(99) < 3);
        seq_left = last ? 0 : seq_left - 1;
        issue_request(cs, rs, last, 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d requests in %0d closed sequences over %0d column settings,",
             n_requests, n_seqs, n_cfg);
    $display("with %0d placements checked, %0d of them past the row store.",
             n_results, n_overflows);
    if (errors == 0) begin
      $display("tb_grid_auto_placement_unit: done, clean");
    end else begin
      $display("tb_grid_auto_placement_unit: done, errors");
    end
    $finish;
  end

endmodule
